>>> hdl/hafd_pkg.sv
// ----------------------------------------------------------------------------
// HDLC async frame decoder package
// Shared constants, status and control codes, state type and the CRC step.
// ----------------------------------------------------------------------------
package hafd_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 64;
   localparam int OCTET_W              = 8;
   localparam int STATUS_W             = 3;
   localparam int INFO_LEN_W           = 6;
   localparam int CSR_INDEX_W          = 2;
   localparam int MIN_FRAME            = 4;
   localparam int HEADER_OCTETS        = 2;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_GOOD = 16'hF0B8;

   localparam logic [OCTET_W-1:0] FLAG_RESET   = 8'h7E;
   localparam logic [OCTET_W-1:0] ESCAPE_RESET = 8'h7D;
   localparam logic [OCTET_W-1:0] MASK_RESET   = 8'h20;

   typedef enum logic [STATUS_W-1:0] {
      ST_FRAME      = 3'd1,
      ST_TOO_SHORT  = 3'd2,
      ST_BAD_FCS    = 3'd3,
      ST_BAD_ESCAPE = 3'd4,
      ST_TOO_LONG   = 3'd5
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FLAG   = 2'd0,
      CSR_ESCAPE = 2'd1,
      CSR_MASK   = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HDR_ADDR,
      BK_HDR_CTRL,
      BK_EMIT,
      BK_READ
   } back_state_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                            input logic [OCTET_W-1:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> hdl/hafd_ifs.sv
// ----------------------------------------------------------------------------
// HDLC async frame decoder channels
// Request channel carrying wire octets and response channel carrying results.
// ----------------------------------------------------------------------------
interface hafd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] octet;

   modport source(output valid, output octet, input ready);
   modport sink(input valid, input octet, output ready);
endinterface

interface hafd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] frame_address;
   logic [7:0] frame_control;
   logic [5:0] info_length;
   logic [7:0] info_byte;
   logic       info_valid;
   logic       last;

   modport source(output valid, output status, output frame_address, output frame_control,
                  output info_length, output info_byte, output info_valid, output last,
                  input ready);
   modport sink(input valid, input status, input frame_address, input frame_control,
                input info_length, input info_byte, input info_valid, input last,
                output ready);
endinterface

>>> hdl/hafd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hafd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/hafd_queue.sv
// ----------------------------------------------------------------------------
// HDLC async frame decoder command queue
// Two-entry FIFO of frame verdicts between the front and the back.
// ----------------------------------------------------------------------------
module hafd_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/hafd_front.sv
// ----------------------------------------------------------------------------
// HDLC async frame decoder front
// Classifies wire octets, unstuffs, stores the frame, runs the CRC and
// queues one verdict per closed or overflowed frame.
// ----------------------------------------------------------------------------
module hafd_front #(
   parameter int BUFFER_DEPTH = hafd_pkg::BUFFER_DEPTH_DEFAULT,
   localparam int ADDR_W = $clog2(BUFFER_DEPTH),
   localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1),
   localparam int CMD_W  = hafd_pkg::STATUS_W + LEN_W
) (
   input  logic                                clock,
   input  logic                                reset,
   hafd_req_if.sink                            req_port,
   input  logic                                csr_write_enable,
   input  logic [hafd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [hafd_pkg::OCTET_W-1:0]        csr_write_data,
   output logic                                store_write_enable,
   output logic [ADDR_W-1:0]                   store_write_address,
   output logic [hafd_pkg::OCTET_W-1:0]        store_write_data,
   output logic                                cmd_push,
   output logic [CMD_W-1:0]                    cmd_data,
   input  logic                                cmd_full,
   input  logic                                frame_done
);

   logic [hafd_pkg::OCTET_W-1:0] flag_ff, escape_octet_ff, mask_ff;
   logic                         frame_open_ff, frame_open_in;
   logic                         escape_ff, escape_in;
   logic                         dropping_ff, dropping_in;
   logic                         pending_ff, pending_in;
   logic [LEN_W-1:0]             length_ff, length_in;
   logic [15:0]                  crc_ff, crc_in;
   logic                         accept;
   logic [hafd_pkg::OCTET_W-1:0] unstuffed;
   hafd_pkg::status_type         cmd_status;

   assign req_port.ready      = !pending_ff && !cmd_full;
   assign accept              = req_port.valid && req_port.ready;
   assign unstuffed           = escape_ff ? (req_port.octet ^ mask_ff) : req_port.octet;
   assign store_write_address = length_ff[ADDR_W-1:0];
   assign store_write_data    = unstuffed;
   assign cmd_data            = {cmd_status, length_ff};

   always_comb begin
      frame_open_in      = frame_open_ff;
      escape_in          = escape_ff;
      dropping_in        = dropping_ff;
      length_in          = length_ff;
      crc_in             = crc_ff;
      pending_in         = pending_ff && !frame_done;
      cmd_push           = 1'b0;
      cmd_status         = hafd_pkg::ST_TOO_LONG;
      store_write_enable = 1'b0;
      if (accept) begin
         if (req_port.octet == flag_ff) begin
            if (frame_open_ff && escape_ff) begin
               cmd_push   = 1'b1;
               cmd_status = hafd_pkg::ST_BAD_ESCAPE;
            end else if (frame_open_ff && !dropping_ff && length_ff != '0) begin
               cmd_push = 1'b1;
               if (length_ff < LEN_W'(hafd_pkg::MIN_FRAME)) begin
                  cmd_status = hafd_pkg::ST_TOO_SHORT;
               end else if (crc_ff != hafd_pkg::CRC_GOOD) begin
                  cmd_status = hafd_pkg::ST_BAD_FCS;
               end else begin
                  cmd_status = hafd_pkg::ST_FRAME;
                  pending_in = 1'b1;
               end
            end
            length_in     = '0;
            crc_in        = hafd_pkg::CRC_INIT;
            frame_open_in = 1'b1;
            escape_in     = 1'b0;
            dropping_in   = 1'b0;
         end else if (frame_open_ff && !dropping_ff) begin
            if (!escape_ff && req_port.octet == escape_octet_ff) begin
               escape_in = 1'b1;
            end else begin
               escape_in = 1'b0;
               if (length_ff == LEN_W'(BUFFER_DEPTH)) begin
                  dropping_in = 1'b1;
                  cmd_push    = 1'b1;
                  cmd_status  = hafd_pkg::ST_TOO_LONG;
               end else begin
                  store_write_enable = 1'b1;
                  length_in          = length_ff + LEN_W'(1);
                  crc_in             = hafd_pkg::crc_byte(crc_ff, unstuffed);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         escape_ff     <= 1'b0;
         dropping_ff   <= 1'b0;
         pending_ff    <= 1'b0;
         length_ff     <= '0;
         crc_ff        <= hafd_pkg::CRC_INIT;
      end else begin
         frame_open_ff <= frame_open_in;
         escape_ff     <= escape_in;
         dropping_ff   <= dropping_in;
         pending_ff    <= pending_in;
         length_ff     <= length_in;
         crc_ff        <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff         <= hafd_pkg::FLAG_RESET;
         escape_octet_ff <= hafd_pkg::ESCAPE_RESET;
         mask_ff         <= hafd_pkg::MASK_RESET;
      end else if (csr_write_enable) begin
         case (hafd_pkg::csr_index_type'(csr_index))
            hafd_pkg::CSR_FLAG:   flag_ff         <= csr_write_data;
            hafd_pkg::CSR_ESCAPE: escape_octet_ff <= csr_write_data;
            hafd_pkg::CSR_MASK:   mask_ff         <= csr_write_data;
            default:              ;
         endcase
      end
   end

endmodule

>>> hdl/hafd_back.sv
// ----------------------------------------------------------------------------
// HDLC async frame decoder back
// Turns queued verdicts into results: one error result, or a header result
// followed by the information octets read back from the frame store.
// ----------------------------------------------------------------------------
module hafd_back #(
   parameter int BUFFER_DEPTH = hafd_pkg::BUFFER_DEPTH_DEFAULT,
   localparam int ADDR_W = $clog2(BUFFER_DEPTH),
   localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1),
   localparam int CMD_W  = hafd_pkg::STATUS_W + LEN_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  logic [CMD_W-1:0]             cmd_data,
   output logic                         cmd_pop,
   output logic                         store_read_enable,
   output logic [ADDR_W-1:0]            store_read_address,
   input  logic [hafd_pkg::OCTET_W-1:0] store_read_data,
   output logic                         frame_done,
   hafd_rsp_if.source                   rsp_port
);

   hafd_pkg::back_state_type state_ff, state_in;
   logic [LEN_W-1:0]             count_ff, count_in;
   logic [LEN_W-1:0]             info_count_ff, info_count_in;
   logic [LEN_W-1:0]             count_next;
   logic [hafd_pkg::OCTET_W-1:0] address_ff, address_in;
   logic [hafd_pkg::OCTET_W-1:0] control_ff, control_in;
   logic                         out_valid_ff, out_valid_in;
   hafd_pkg::status_type         out_status_ff, out_status_in;
   logic [hafd_pkg::OCTET_W-1:0] out_address_ff, out_address_in;
   logic [hafd_pkg::OCTET_W-1:0] out_control_ff, out_control_in;
   logic [hafd_pkg::INFO_LEN_W-1:0] out_length_ff, out_length_in;
   logic [hafd_pkg::OCTET_W-1:0] out_byte_ff, out_byte_in;
   logic                         out_info_valid_ff, out_info_valid_in;
   logic                         out_last_ff, out_last_in;
   logic                         out_free;
   hafd_pkg::status_type         cmd_status;
   logic [LEN_W-1:0]             cmd_length;

   assign out_free   = !out_valid_ff || rsp_port.ready;
   assign cmd_status = hafd_pkg::status_type'(cmd_data[CMD_W-1 -: hafd_pkg::STATUS_W]);
   assign cmd_length = cmd_data[LEN_W-1:0];
   assign count_next = count_ff + LEN_W'(1);

   assign rsp_port.valid         = out_valid_ff;
   assign rsp_port.status        = out_status_ff;
   assign rsp_port.frame_address = out_address_ff;
   assign rsp_port.frame_control = out_control_ff;
   assign rsp_port.info_length   = out_length_ff;
   assign rsp_port.info_byte     = out_byte_ff;
   assign rsp_port.info_valid    = out_info_valid_ff;
   assign rsp_port.last          = out_last_ff;

   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      info_count_in      = info_count_ff;
      address_in         = address_ff;
      control_in         = control_ff;
      out_valid_in       = out_valid_ff && !rsp_port.ready;
      out_status_in      = out_status_ff;
      out_address_in     = out_address_ff;
      out_control_in     = out_control_ff;
      out_length_in      = out_length_ff;
      out_byte_in        = out_byte_ff;
      out_info_valid_in  = out_info_valid_ff;
      out_last_in        = out_last_ff;
      cmd_pop            = 1'b0;
      store_read_enable  = 1'b0;
      store_read_address = '0;
      frame_done         = 1'b0;
      case (state_ff)
         hafd_pkg::BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               if (cmd_status == hafd_pkg::ST_FRAME) begin
                  info_count_in     = cmd_length - LEN_W'(hafd_pkg::MIN_FRAME);
                  store_read_enable = 1'b1;
                  state_in          = hafd_pkg::BK_HDR_ADDR;
               end else begin
                  out_valid_in      = 1'b1;
                  out_status_in     = cmd_status;
                  out_address_in    = '0;
                  out_control_in    = '0;
                  out_length_in     = '0;
                  out_byte_in       = '0;
                  out_info_valid_in = 1'b0;
                  out_last_in       = 1'b1;
               end
            end
         end
         hafd_pkg::BK_HDR_ADDR: begin
            address_in         = store_read_data;
            store_read_enable  = 1'b1;
            store_read_address = ADDR_W'(1);
            state_in           = hafd_pkg::BK_HDR_CTRL;
         end
         hafd_pkg::BK_HDR_CTRL: begin
            control_in        = store_read_data;
            count_in          = '0;
            out_valid_in      = 1'b1;
            out_status_in     = hafd_pkg::ST_FRAME;
            out_address_in    = address_ff;
            out_control_in    = store_read_data;
            out_length_in     = hafd_pkg::INFO_LEN_W'(info_count_ff);
            out_byte_in       = '0;
            out_info_valid_in = 1'b0;
            out_last_in       = (info_count_ff == '0);
            if (info_count_ff == '0) begin
               frame_done = 1'b1;
               state_in   = hafd_pkg::BK_IDLE;
            end else begin
               state_in = hafd_pkg::BK_EMIT;
            end
         end
         hafd_pkg::BK_EMIT: begin
            if (out_free) begin
               store_read_enable  = 1'b1;
               store_read_address = ADDR_W'(count_ff + LEN_W'(hafd_pkg::HEADER_OCTETS));
               state_in           = hafd_pkg::BK_READ;
            end
         end
         hafd_pkg::BK_READ: begin
            count_in          = count_next;
            out_valid_in      = 1'b1;
            out_status_in     = hafd_pkg::ST_FRAME;
            out_address_in    = address_ff;
            out_control_in    = control_ff;
            out_length_in     = hafd_pkg::INFO_LEN_W'(info_count_ff);
            out_byte_in       = store_read_data;
            out_info_valid_in = 1'b1;
            out_last_in       = (count_next == info_count_ff);
            if (count_next == info_count_ff) begin
               frame_done = 1'b1;
               state_in   = hafd_pkg::BK_IDLE;
            end else begin
               state_in = hafd_pkg::BK_EMIT;
            end
         end
         default: begin
            state_in = hafd_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hafd_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff          <= count_in;
      info_count_ff     <= info_count_in;
      address_ff        <= address_in;
      control_ff        <= control_in;
      out_status_ff     <= out_status_in;
      out_address_ff    <= out_address_in;
      out_control_ff    <= out_control_in;
      out_length_ff     <= out_length_in;
      out_byte_ff       <= out_byte_in;
      out_info_valid_ff <= out_info_valid_in;
      out_last_ff       <= out_last_in;
   end

endmodule

>>> hdl/hdlc_async_frame_decoder.sv
// ----------------------------------------------------------------------------
// HDLC async frame decoder
// Removes asynchronous HDLC framing and checks the CRC-16/X.25 frame check.
// ----------------------------------------------------------------------------
// The block takes one wire octet per cycle on the request channel while it is
// not holding off requests. Error verdicts (too short, bad FCS, bad escape, too
// long) pass through a two-entry queue and come out as single results without
// slowing the input while the response side is ready; a stalled response side
// fills the queue and then holds off requests. After the closing flag of a good
// frame, requests are held off until the back end has read the frame out of the
// frame store: once the verdict is taken, the address octet is read out
// (BK_HDR_ADDR), then the header result is loaded with the control octet
// (BK_HDR_CTRL), and each information octet takes one store read (BK_EMIT,
// which waits while the response side is stalled) and one output register load
// (BK_READ). The frame store is not cleared; no reset sweep is needed.
module hdlc_async_frame_decoder #(
   parameter int BUFFER_DEPTH = hafd_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   hafd_req_if.sink                         req_port,
   hafd_rsp_if.source                       rsp_port,
   input  logic                             csr_write_enable,
   input  logic [hafd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hafd_pkg::OCTET_W-1:0]     csr_write_data
);

   localparam int ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int LEN_W  = $clog2(BUFFER_DEPTH + 1);
   localparam int CMD_W  = hafd_pkg::STATUS_W + LEN_W;

   logic                         store_write_enable;
   logic [ADDR_W-1:0]            store_write_address;
   logic [hafd_pkg::OCTET_W-1:0] store_write_data;
   logic                         store_read_enable;
   logic [ADDR_W-1:0]            store_read_address;
   logic [hafd_pkg::OCTET_W-1:0] store_read_data;
   logic                         cmd_push;
   logic [CMD_W-1:0]             cmd_push_data;
   logic                         cmd_full;
   logic                         cmd_pop;
   logic [CMD_W-1:0]             cmd_pop_data;
   logic                         cmd_valid;
   logic                         frame_done;

   hafd_front #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .req_port            (req_port),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .store_write_enable  (store_write_enable),
      .store_write_address (store_write_address),
      .store_write_data    (store_write_data),
      .cmd_push            (cmd_push),
      .cmd_data            (cmd_push_data),
      .cmd_full            (cmd_full),
      .frame_done          (frame_done)
   );

   hafd_queue #(
      .WIDTH(CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_pop_data),
      .not_empty (cmd_valid)
   );

   hafd_ram #(
      .WIDTH(hafd_pkg::OCTET_W),
      .DEPTH(BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (store_write_enable),
      .wr_addr (store_write_address),
      .wr_data (store_write_data),
      .rd_en   (store_read_enable),
      .rd_addr (store_read_address),
      .rd_data (store_read_data)
   );

   hafd_back #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd_data           (cmd_pop_data),
      .cmd_pop            (cmd_pop),
      .store_read_enable  (store_read_enable),
      .store_read_address (store_read_address),
      .store_read_data    (store_read_data),
      .frame_done         (frame_done),
      .rsp_port           (rsp_port)
   );

endmodule

>>> hdl/hafd_checker.sv
// ----------------------------------------------------------------------------
// HDLC async frame decoder checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module hafd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_frame_address,
   input logic [7:0] rsp_frame_control,
   input logic [5:0] rsp_info_length,
   input logic [7:0] rsp_info_byte,
   input logic       rsp_info_valid,
   input logic       rsp_last
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_status, rsp_frame_address,
         rsp_frame_control, rsp_info_length, rsp_info_byte, rsp_info_valid, rsp_last}))
      else $error("stalled response changed");

   a_info_in_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_info_valid |-> rsp_status == hafd_pkg::ST_FRAME)
      else $error("information octet outside a good frame");

   a_error_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != hafd_pkg::ST_FRAME |-> rsp_last && !rsp_info_valid &&
         rsp_frame_address == 8'h00 && rsp_frame_control == 8'h00 &&
         rsp_info_length == 6'h00 && rsp_info_byte == 8'h00)
      else $error("malformed error result");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == hafd_pkg::ST_FRAME && !rsp_info_valid && rsp_last
         |-> rsp_info_length == 6'h00 && rsp_info_byte == 8'h00)
      else $error("final header result of a frame with information octets");

endmodule

bind hdlc_async_frame_decoder hafd_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_port.valid),
   .rsp_ready         (rsp_port.ready),
   .rsp_status        (rsp_port.status),
   .rsp_frame_address (rsp_port.frame_address),
   .rsp_frame_control (rsp_port.frame_control),
   .rsp_info_length   (rsp_port.info_length),
   .rsp_info_byte     (rsp_port.info_byte),
   .rsp_info_valid    (rsp_port.info_valid),
   .rsp_last          (rsp_port.last)
);

>>> test/deframer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDLC async frame decoder checker
// Watches the request, response and register ports of the decoder. It keeps
// its own deframing state and CRC-16/X.25 to work out the expected results for
// every accepted octet. It then compares each accepted result field by field
// with the oldest one still due.
// ----------------------------------------------------------------------------
module deframer_checker #(
   parameter int DEPTH = hafd_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   hafd_req_if                              req_mon,
   hafd_rsp_if                              rsp_mon,
   input  logic                             csr_write_enable,
   input  logic [hafd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [hafd_pkg::OCTET_W-1:0]     csr_write_data,
   output int                               fail_count,
   output int                               pending,
   output int                               good_frame_count,
   output int                               verdict_count
);

   typedef struct packed {
      hafd_pkg::status_type status;
      logic [7:0]           address;
      logic [7:0]           control;
      logic [5:0]           length;
      logic [7:0]           data;
      logic                 data_valid;
      logic                 is_last;
   } frame_result_type;

   frame_result_type due_results[$];

   logic [7:0]  flag_cfg;
   logic [7:0]  escape_cfg;
   logic [7:0]  mask_cfg;
   logic        frame_open;
   logic        escape_open;
   logic        dropping;
   int          frame_len;
   logic [7:0]  frame_copy[DEPTH];
   logic [15:0] fcs_acc;
   int          mismatches = 0;
   int          frames_seen = 0;
   int          verdicts_seen = 0;

   function automatic logic [15:0] fcs_advance(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ b[k];
         r = r >> 1;
         if (fb) r = r ^ hafd_pkg::CRC_POLY;
      end
      return r;
   endfunction

   task automatic push_result(input hafd_pkg::status_type st, input logic [7:0] a,
                              input logic [7:0] c, input logic [5:0] n, input logic [7:0] d,
                              input logic dv, input logic lst);
      due_results.push_back(frame_result_type'{st, a, c, n, d, dv, lst});
   endtask

   task automatic push_verdict(input hafd_pkg::status_type st);
      push_result(st, 8'h00, 8'h00, 6'd0, 8'h00, 1'b0, 1'b1);
      verdicts_seen++;
   endtask

   task automatic close_frame();
      int         n;
      logic [5:0] n6;
      if (frame_len < hafd_pkg::MIN_FRAME) begin
         push_verdict(hafd_pkg::ST_TOO_SHORT);
      end else if (fcs_acc != hafd_pkg::CRC_GOOD) begin
         push_verdict(hafd_pkg::ST_BAD_FCS);
      end else begin
         n = frame_len - hafd_pkg::MIN_FRAME;
         n6 = n[5:0];
         push_result(hafd_pkg::ST_FRAME, frame_copy[0], frame_copy[1], n6, 8'h00, 1'b0,
                     n == 0);
         for (int i = 0; i < n; i++)
            push_result(hafd_pkg::ST_FRAME, frame_copy[0], frame_copy[1], n6,
                        frame_copy[i + 2], 1'b1, i + 1 == n);
         frames_seen++;
      end
   endtask

   task automatic unstuff_octet(input logic [7:0] b);
      logic [7:0] v;
      if (b == flag_cfg) begin
         if (frame_open && escape_open) push_verdict(hafd_pkg::ST_BAD_ESCAPE);
         else if (frame_open && !dropping && frame_len != 0) close_frame();
         frame_len = 0;
         fcs_acc = hafd_pkg::CRC_INIT;
         frame_open = 1'b1;
         escape_open = 1'b0;
         dropping = 1'b0;
      end else if (frame_open && !dropping) begin
         if (!escape_open && b == escape_cfg) begin
            escape_open = 1'b1;
         end else begin
            v = escape_open ? (b ^ mask_cfg) : b;
            escape_open = 1'b0;
            if (frame_len >= DEPTH) begin
               dropping = 1'b1;
               push_verdict(hafd_pkg::ST_TOO_LONG);
            end else begin
               frame_copy[frame_len] = v;
               frame_len++;
               fcs_acc = fcs_advance(fcs_acc, v);
            end
         end
      end
   endtask

   task automatic match_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= 40)
            $error("checker: %s expected %0d, got %0d", name, want, got);
      end
   endtask

   task automatic compare_response();
      frame_result_type want;
      if (due_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 40)
            $error("checker: status expected none, got %0d", rsp_mon.status);
      end else begin
         want = due_results.pop_front();
         match_field("status", want.status, rsp_mon.status);
         match_field("frame_address", want.address, rsp_mon.frame_address);
         match_field("frame_control", want.control, rsp_mon.frame_control);
         match_field("info_length", want.length, rsp_mon.info_length);
         match_field("info_byte", want.data, rsp_mon.info_byte);
         match_field("info_valid", want.data_valid, rsp_mon.info_valid);
         match_field("last", want.is_last, rsp_mon.last);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         flag_cfg = hafd_pkg::FLAG_RESET;
         escape_cfg = hafd_pkg::ESCAPE_RESET;
         mask_cfg = hafd_pkg::MASK_RESET;
         frame_open = 1'b0;
         escape_open = 1'b0;
         dropping = 1'b0;
         frame_len = 0;
         fcs_acc = hafd_pkg::CRC_INIT;
         due_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               hafd_pkg::CSR_FLAG:   flag_cfg = csr_write_data;
               hafd_pkg::CSR_ESCAPE: escape_cfg = csr_write_data;
               hafd_pkg::CSR_MASK:   mask_cfg = csr_write_data;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) compare_response();
         if (req_mon.valid && req_mon.ready) unstuff_octet(req_mon.octet);
      end
      fail_count <= mismatches;
      pending <= due_results.size();
      good_frame_count <= frames_seen;
      verdict_count <= verdicts_seen;
   end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HDLC async frame decoder testbench
// Feeds wire octets to the decoder under several delimiter, escape and mask
// settings: directed frames first, then random mixes of good, corrupted,
// short, long and broken frames with noise. A long response stall fills the
// decoder. The checker beside the decoder predicts and compares all results.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DEPTH       = hafd_pkg::BUFFER_DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_TAIL  = 16;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [hafd_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [hafd_pkg::OCTET_W-1:0]     csr_write_data;
   logic                             calm;
   logic                             hold_go;
   int                               fail_count;
   int                               pending;
   int                               good_frame_count;
   int                               verdict_count;
   int                               cycle_count = 0;
   int                               sent = 0;
   int                               settings = 1;
   logic [7:0]                       cur_flag = hafd_pkg::FLAG_RESET;
   logic [7:0]                       cur_esc = hafd_pkg::ESCAPE_RESET;
   logic [7:0]                       cur_mask = hafd_pkg::MASK_RESET;
   logic [7:0]                       body[$];

   hafd_req_if req_bus();
   hafd_rsp_if rsp_bus();

   hdlc_async_frame_decoder #(.BUFFER_DEPTH(DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_bus),
      .rsp_port         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   deframer_checker #(.DEPTH(DEPTH)) watcher (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_bus),
      .rsp_mon          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .good_frame_count (good_frame_count),
      .verdict_count    (verdict_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("testbench: done, errors");
      $finish;
   end

   // response side: random stalls, one long hold-off when asked
   initial begin
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 6);
         end
      end
   end

   function automatic logic [15:0] fcs_next(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      r = acc ^ {8'h00, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ hafd_pkg::CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic logic [7:0] pick_octet();
      int r;
      r = $urandom_range(99);
      if (r < 8) return cur_flag;
      if (r < 16) return cur_esc;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_octet(input logic [7:0] value);
      while (!calm && $urandom_range(99) < 6) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.octet <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_stuffed(input logic [7:0] b);
      if (b == cur_flag || b == cur_esc ||
          ((b ^ cur_mask) != cur_flag && $urandom_range(99) < 4)) begin
         send_octet(cur_esc);
         send_octet(b ^ cur_mask);
      end else begin
         send_octet(b);
      end
   endtask

   task automatic fill_body(input int n);
      body.delete();
      repeat (n + 2) body.push_back(pick_octet());
   endtask

   // append FCS low byte first, stuff, close with a flag
   task automatic send_frame(input bit corrupt);
      logic [15:0] acc;
      logic [7:0]  frame_bytes[$];
      int          pos;
      acc = hafd_pkg::CRC_INIT;
      frame_bytes = body;
      foreach (body[k]) acc = fcs_next(acc, body[k]);
      acc = ~acc;
      frame_bytes.push_back(acc[7:0]);
      frame_bytes.push_back(acc[15:8]);
      if (corrupt) begin
         pos = $urandom_range(frame_bytes.size() - 1);
         frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(7));
      end
      foreach (frame_bytes[k]) send_stuffed(frame_bytes[k]);
      send_octet(cur_flag);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic apply_config(input logic [7:0] f, input logic [7:0] e, input logic [7:0] m);
      settle();
      csr_write_enable <= 1'b1;
      csr_index <= hafd_pkg::CSR_FLAG;
      csr_write_data <= f;
      @(posedge clock);
      csr_index <= hafd_pkg::CSR_ESCAPE;
      csr_write_data <= e;
      @(posedge clock);
      csr_index <= hafd_pkg::CSR_MASK;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_flag = f;
      cur_esc = e;
      cur_mask = m;
      settings++;
   endtask

   task automatic random_traffic(input int count);
      int stop;
      int pick;
      int n;
      stop = sent + count;
      send_octet(cur_flag);
      while (sent < stop) begin
         pick = $urandom_range(99);
         n = ($urandom_range(9) == 0) ? $urandom_range(9, 60) : $urandom_range(8);
         if (pick < 55) begin
            fill_body(n);
            send_frame(1'b0);
         end else if (pick < 65) begin
            fill_body(n);
            send_frame(1'b1);
         end else if (pick < 72) begin
            repeat ($urandom_range(1, 3)) send_stuffed(pick_octet());
            send_octet(cur_flag);
         end else if (pick < 79) begin
            repeat ($urandom_range(5)) send_stuffed(pick_octet());
            send_octet(cur_esc);
            send_octet(cur_flag);
         end else if (pick < 82) begin
            fill_body(DEPTH - 2 + $urandom_range(1, 4));
            send_frame(1'b0);
         end else if (pick < 88) begin
            send_octet(cur_flag);
         end else begin
            repeat ($urandom_range(1, 6)) send_octet(pick_octet());
         end
      end
      send_octet(cur_flag);
   endtask

   initial begin
      logic [7:0] f;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.octet <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_index <= hafd_pkg::CSR_FLAG;
      csr_write_data <= 8'h00;
      calm <= 1'b0;
      hold_go <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ignored before the first flag, then an empty frame, a short frame and a bad escape
      send_octet(8'h00);
      send_octet(8'hFF);
      send_octet(cur_flag);
      send_octet(cur_flag);
      send_octet(8'h11);
      send_octet(cur_flag);
      send_octet(8'h22);
      send_octet(cur_esc);
      send_octet(cur_flag);
      body = {8'hFF, 8'h03};
      send_frame(1'b0);
      body = {8'h00, 8'hFF, 8'h7E, 8'h7D, 8'h00, 8'hFF};
      send_frame(1'b0);
      body = {8'h5A, 8'hA5};
      send_frame(1'b1);

      // overflow, then drop to the next flag
      fill_body(DEPTH + 3);
      send_frame(1'b0);
      random_traffic(25);

      apply_config(8'h00, 8'hFF, 8'hFF);
      calm <= 1'b1;
      random_traffic(25);

      apply_config(8'hFF, 8'h00, 8'h01);
      calm <= 1'b0;
      random_traffic(20);

      apply_config(8'h55, 8'h55, 8'h80);
      random_traffic(15);

      f = 8'($urandom_range(255));
      apply_config(f, f ^ 8'($urandom_range(1, 255)), 8'h00);
      random_traffic(15);

      // stall the response side while frames keep coming
      apply_config(hafd_pkg::FLAG_RESET, hafd_pkg::ESCAPE_RESET, hafd_pkg::MASK_RESET);
      hold_go <= 1'b1;
      send_octet(cur_flag);
      repeat (4) begin
         fill_body($urandom_range(2, 6));
         send_frame(1'b0);
         send_stuffed(pick_octet());
         send_octet(cur_flag);
      end
      fill_body(60);
      send_frame(1'b0);

      settle();
      $display("testbench: %0d requests over %0d register settings", sent, settings);
      $display("testbench: %0d good frames and %0d error verdicts predicted",
               good_frame_count, verdict_count);
      if (fail_count == 0 && pending == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
